### rtl/utf8p_pkg.sv
`timescale 1ns / 1ps

package utf8p_pkg;

    // Width of the internal line and column counters; results carry the low 16 bits.
    localparam int LINE_BITS    = 16;
    localparam int COLUMN_BITS  = 16;
    localparam int POS_OUT_BITS = 16;
    localparam int CP_BITS      = 21;

    localparam logic [CP_BITS-1:0] REPLACEMENT_CP = 21'h00FFFD;
    localparam logic [CP_BITS-1:0] NEWLINE_CP     = 21'h00000A;

    // One input word expands into a run of up to four result words: a block of
    // replacement characters, at most one decoded character, more replacements.
    typedef struct packed {
        logic [2:0]         n;         // result words in the run, 0..4
        logic               has_char;  // one entry is a well formed character
        logic [1:0]         char_idx;  // its place in the run
        logic [CP_BITS-1:0] cp;        // its code point
        logic [2:0]         nb;        // its byte count
        logic               eos;       // positions return to 1:1 after the run
    } run_t;

    function automatic logic [POS_OUT_BITS-1:0] line_out(input logic [LINE_BITS-1:0] v);
        logic [LINE_BITS+POS_OUT_BITS-1:0] wide;
        wide = {{POS_OUT_BITS{1'b0}}, v};
        return wide[POS_OUT_BITS-1:0];
    endfunction

    function automatic logic [POS_OUT_BITS-1:0] column_out(input logic [COLUMN_BITS-1:0] v);
        logic [COLUMN_BITS+POS_OUT_BITS-1:0] wide;
        wide = {{POS_OUT_BITS{1'b0}}, v};
        return wide[POS_OUT_BITS-1:0];
    endfunction

endpackage

### rtl/utf8p_if.sv
`timescale 1ns / 1ps

interface utf8p_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_source;

    modport source (output valid, output data_byte, output end_of_source, input ready);
    modport sink   (input valid, input data_byte, input end_of_source, output ready);
endinterface

interface utf8p_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [utf8p_pkg::CP_BITS-1:0]         codepoint;
    logic                                  char_valid;
    logic [2:0]                            byte_count;
    logic [utf8p_pkg::POS_OUT_BITS-1:0]    line_number;
    logic [utf8p_pkg::POS_OUT_BITS-1:0]    column_number;
    logic                                  last_of_run;

    modport source (output valid, output codepoint, output char_valid, output byte_count,
                    output line_number, output column_number, output last_of_run,
                    input ready);
    modport sink   (input valid, input codepoint, input char_valid, input byte_count,
                    input line_number, input column_number, input last_of_run,
                    output ready);
endinterface

### rtl/utf8p_decode.sv
`timescale 1ns / 1ps

module utf8p_decode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        data_byte,
    input  logic              end_of_source,
    input  logic              run_take,
    output logic              run_valid,
    output utf8p_pkg::run_t   run
);

    localparam logic [1:0] CONT_TAG  = 2'b10;
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;

    logic [1:0]                     need_reg, need_next;
    logic [1:0]                     held_reg, held_next;
    logic [utf8p_pkg::CP_BITS-1:0]  part_reg, part_next;
    logic                           run_valid_reg, run_valid_next;
    utf8p_pkg::run_t                run_reg, run_next;

    logic                           accept;
    logic                           is_cont;
    logic [utf8p_pkg::CP_BITS-1:0]  ext_cp;
    logic [1:0]                     held_inc;
    logic [2:0]                     pre_cnt;
    logic [2:0]                     post_cnt;
    logic                           mid_char;
    logic                           mid_bad;
    logic [utf8p_pkg::CP_BITS-1:0]  char_cp;
    logic [2:0]                     char_nb;

    assign in_ready  = !run_valid_reg || run_take;
    assign accept    = in_valid && in_ready;
    assign run_valid = run_valid_reg;
    assign run       = run_reg;

    assign is_cont  = (data_byte[7:6] == CONT_TAG);
    assign ext_cp   = {part_reg[utf8p_pkg::CP_BITS-7:0], data_byte[5:0]};
    assign held_inc = held_reg + 2'd1;

    always_comb
    begin
        need_next = need_reg;
        held_next = held_reg;
        part_next = part_reg;
        pre_cnt   = 3'd0;
        post_cnt  = 3'd0;
        mid_char  = 1'b0;
        mid_bad   = 1'b0;
        char_cp   = '0;
        char_nb   = 3'd1;

        if (need_reg != 2'd0 && is_cont)
        begin
            if (held_inc >= need_reg)
            begin
                mid_char  = 1'b1;
                char_cp   = ext_cp;
                char_nb   = {1'b0, need_reg} + 3'd1;
                need_next = 2'd0;
                held_next = 2'd0;
                part_next = '0;
            end
            else
            begin
                held_next = held_inc;
                part_next = ext_cp;
            end
        end
        else
        begin
            // broken sequence: one replacement for the lead and one per held byte
            if (need_reg != 2'd0)
                pre_cnt = {1'b0, held_reg} + 3'd1;
            need_next = 2'd0;
            held_next = 2'd0;
            part_next = '0;
            if (!data_byte[7])
            begin
                mid_char = 1'b1;
                char_cp  = {{(utf8p_pkg::CP_BITS-8){1'b0}}, data_byte};
            end
            else if (data_byte[7:5] == LEAD2_TAG)
            begin
                need_next = 2'd1;
                part_next = {{(utf8p_pkg::CP_BITS-5){1'b0}}, data_byte[4:0]};
            end
            else if (data_byte[7:4] == LEAD3_TAG)
            begin
                need_next = 2'd2;
                part_next = {{(utf8p_pkg::CP_BITS-4){1'b0}}, data_byte[3:0]};
            end
            else if (data_byte[7:3] == LEAD4_TAG)
            begin
                need_next = 2'd3;
                part_next = {{(utf8p_pkg::CP_BITS-3){1'b0}}, data_byte[2:0]};
            end
            else
            begin
                mid_bad = 1'b1;
            end
        end

        // end of source flushes whatever is still pending, then clears
        if (end_of_source)
        begin
            if (need_next != 2'd0)
                post_cnt = {1'b0, held_next} + 3'd1;
            need_next = 2'd0;
            held_next = 2'd0;
            part_next = '0;
        end
    end

    always_comb
    begin
        run_next.n        = pre_cnt + {2'b00, (mid_char || mid_bad)} + post_cnt;
        run_next.has_char = mid_char;
        run_next.char_idx = pre_cnt[1:0];
        run_next.cp       = char_cp;
        run_next.nb       = char_nb;
        run_next.eos      = end_of_source;

        if (accept)
            run_valid_next = (run_next.n != 3'd0);
        else if (run_take)
            run_valid_next = 1'b0;
        else
            run_valid_next = run_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            need_reg      <= 2'd0;
            held_reg      <= 2'd0;
            part_reg      <= '0;
            run_valid_reg <= 1'b0;
        end
        else
        begin
            run_valid_reg <= run_valid_next;
            if (accept)
            begin
                need_reg <= need_next;
                held_reg <= held_next;
                part_reg <= part_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            run_reg <= run_next;
    end

endmodule

### rtl/utf8p_emit.sv
`timescale 1ns / 1ps

module utf8p_emit (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    run_valid,
    input  utf8p_pkg::run_t         run,
    output logic                    run_take,
    utf8p_out_if.source             chars
);

    logic [1:0]                          idx_reg, idx_next;
    logic [utf8p_pkg::LINE_BITS-1:0]     line_reg, line_next;
    logic [utf8p_pkg::COLUMN_BITS-1:0]   col_reg, col_next;
    logic                                out_valid_reg, out_valid_next;
    logic [utf8p_pkg::CP_BITS-1:0]       cp_reg;
    logic                                cv_reg;
    logic [2:0]                          nb_reg;
    logic [utf8p_pkg::POS_OUT_BITS-1:0]  ln_reg;
    logic [utf8p_pkg::POS_OUT_BITS-1:0]  cn_reg;
    logic                                last_reg;

    logic                                advance;
    logic                                is_char;
    logic                                is_last;
    logic [utf8p_pkg::CP_BITS-1:0]       cur_cp;
    logic [2:0]                          cur_nb;
    logic                                is_newline;

    assign advance    = run_valid && (!out_valid_reg || chars.ready);
    assign is_char    = run.has_char && (idx_reg == run.char_idx);
    assign is_last    = (({1'b0, idx_reg} + 3'd1) == run.n);
    assign cur_cp     = is_char ? run.cp : utf8p_pkg::REPLACEMENT_CP;
    assign cur_nb     = is_char ? run.nb : 3'd1;
    assign is_newline = is_char && (run.cp == utf8p_pkg::NEWLINE_CP);
    assign run_take   = advance && is_last;

    always_comb
    begin
        idx_next  = idx_reg;
        line_next = line_reg;
        col_next  = col_reg;
        if (advance)
        begin
            idx_next = is_last ? 2'd0 : idx_reg + 2'd1;
            if (is_last && run.eos)
            begin
                line_next = {{(utf8p_pkg::LINE_BITS-1){1'b0}}, 1'b1};
                col_next  = {{(utf8p_pkg::COLUMN_BITS-1){1'b0}}, 1'b1};
            end
            else if (is_newline)
            begin
                if (line_reg != {utf8p_pkg::LINE_BITS{1'b1}})
                    line_next = line_reg + 1'b1;
                col_next = {{(utf8p_pkg::COLUMN_BITS-1){1'b0}}, 1'b1};
            end
            else if (col_reg != {utf8p_pkg::COLUMN_BITS{1'b1}})
            begin
                col_next = col_reg + 1'b1;
            end
        end

        if (advance)
            out_valid_next = 1'b1;
        else if (chars.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            line_reg      <= {{(utf8p_pkg::LINE_BITS-1){1'b0}}, 1'b1};
            col_reg       <= {{(utf8p_pkg::COLUMN_BITS-1){1'b0}}, 1'b1};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            line_reg      <= line_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cp_reg   <= cur_cp;
            cv_reg   <= is_char;
            nb_reg   <= cur_nb;
            ln_reg   <= utf8p_pkg::line_out(line_reg);
            cn_reg   <= utf8p_pkg::column_out(col_reg);
            last_reg <= is_last;
        end
    end

    assign chars.valid         = out_valid_reg;
    assign chars.codepoint     = cp_reg;
    assign chars.char_valid    = cv_reg;
    assign chars.byte_count    = nb_reg;
    assign chars.line_number   = ln_reg;
    assign chars.column_number = cn_reg;
    assign chars.last_of_run   = last_reg;

endmodule

### rtl/utf8_decoder_with_position_unit.sv
`timescale 1ns / 1ps

// Streaming UTF-8 decoder that tags each character with its source line and column.
// bytes: one source byte per word, end_of_source marks the last byte of a source.
// chars: one word per character: code point (U+FFFD on error), char_valid,
//        byte_count, 1-based line and column where it starts, last_of_run.
// A byte that only starts or extends a sequence yields no word; a byte that breaks
// a sequence or ends the source can yield up to four words, the last flagged
// last_of_run. A byte's first word passes the decode (run) register, then the output
// register. A byte that yields zero or one word is taken at one byte per cycle while
// the receiver keeps up; a byte that yields several words holds the byte channel
// until the single output register has drained them, one word per cycle while the
// receiver is ready. If the receiver stalls, the output word holds, the run register
// behind it fills, and bytes.ready drops until room frees up.
// Reset clears any pending sequence and sets line and column to 1; end of source
// does the same after its flushed words.
module utf8_decoder_with_position_unit (
    input  logic          clk,
    input  logic          rst_n,
    utf8p_in_if.sink      bytes,
    utf8p_out_if.source   chars
);

    // decoded run of result words handed from the decode stage to the emitter
    logic              run_valid;
    logic              run_take;
    utf8p_pkg::run_t   run;

    // decode stage: sequence state plus the run register
    utf8p_decode u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (bytes.valid),
        .in_ready      (bytes.ready),
        .data_byte     (bytes.data_byte),
        .end_of_source (bytes.end_of_source),
        .run_take      (run_take),
        .run_valid     (run_valid),
        .run           (run)
    );

    // emitter: walks the run one word per cycle while the receiver is ready, owns line/column counters
    utf8p_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .run_valid (run_valid),
        .run       (run),
        .run_take  (run_take),
        .chars     (chars)
    );

endmodule

### rtl/utf8p_checker.sv
`timescale 1ns / 1ps

module utf8p_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [20:0] codepoint,
    input  logic        char_valid,
    input  logic [2:0]  byte_count,
    input  logic [15:0] line_number,
    input  logic [15:0] column_number
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(codepoint) && $stable(column_number))
        else $error("result word changed while stalled");

    a_replacement: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !char_valid |-> codepoint == 21'h00FFFD && byte_count == 3'd1)
        else $error("malformed word is not a one-byte replacement");

    a_ascii_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && char_valid && byte_count == 3'd1 |-> codepoint < 21'h80)
        else $error("one-byte character above ASCII range");

    a_position: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> line_number != 16'd0 && column_number != 16'd0
                      && byte_count != 3'd0 && byte_count <= 3'd4)
        else $error("position or byte count out of range");

endmodule

bind utf8_decoder_with_position_unit utf8p_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (chars.valid),
    .out_ready     (chars.ready),
    .codepoint     (chars.codepoint),
    .char_valid    (chars.char_valid),
    .byte_count    (chars.byte_count),
    .line_number   (chars.line_number),
    .column_number (chars.column_number)
);

### tb/tb_utf8_decoder_with_position_unit.sv
`timescale 1ns / 1ps

// Self-checking bench for the UTF-8 decoder with line/column tagging.
// Stimulus goes through a byte queue, results are checked against a predictor
// as they arrive on the char channel.
module tb_utf8_decoder_with_position_unit;

    // One char word as it appears on the output channel.
    typedef struct packed {
        logic [utf8p_pkg::CP_BITS-1:0]      cp;
        logic                               ok;
        logic [2:0]                         nb;
        logic [utf8p_pkg::POS_OUT_BITS-1:0] line;
        logic [utf8p_pkg::POS_OUT_BITS-1:0] col;
        logic                               last;
    } char_word_t;

    // One source byte plus an optional hand-written expectation for the
    // final word it produces (typed rows of the directed table).
    typedef struct packed {
        logic [7:0] b;
        logic       eos;
        logic       typed;
        char_word_t want;
    } byte_item_t;

    localparam char_word_t NO_CHECK = '0;

    logic clk;
    logic rst_n;

    utf8p_in_if  bytes ();
    utf8p_out_if chars ();

    utf8_decoder_with_position_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .bytes (bytes),
        .chars (chars)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop well above the slowest legal run (about 270 bytes, each up to
    // four words, under the worst stall pattern and the long receiver hold).
    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Directed table. Rows with typed=1 carry the expected final word of
    // the run; the rest are left to the predictor.
    // Position notes: the newline in row 2 moves to 2:1; the two stray bytes
    // land on columns 4 and 5; end of source in row 19 puts us back at 1:1.
    // ------------------------------------------------------------------
    byte_item_t dir_tab [25] = '{
        // ASCII extremes and newline
        '{8'h00, 1'b0, 1'b1, '{21'h000000, 1'b1, 3'd1, 16'd1, 16'd1, 1'b1}},
        '{8'h7F, 1'b0, 1'b1, '{21'h00007F, 1'b1, 3'd1, 16'd1, 16'd2, 1'b1}},
        '{8'h0A, 1'b0, 1'b1, '{utf8p_pkg::NEWLINE_CP, 1'b1, 3'd1, 16'd1, 16'd3, 1'b1}},
        // two- and three-byte sequences
        '{8'hC3, 1'b0, 1'b0, NO_CHECK},
        '{8'hA9, 1'b0, 1'b0, NO_CHECK},
        '{8'hE2, 1'b0, 1'b0, NO_CHECK},
        '{8'h82, 1'b0, 1'b0, NO_CHECK},
        '{8'hAC, 1'b0, 1'b0, NO_CHECK},
        // four-byte sequence with every payload bit set: largest code point
        '{8'hF7, 1'b0, 1'b0, NO_CHECK},
        '{8'hBF, 1'b0, 1'b0, NO_CHECK},
        '{8'hBF, 1'b0, 1'b0, NO_CHECK},
        '{8'hBF, 1'b0, 1'b1, '{21'h1FFFFF, 1'b1, 3'd4, 16'd2, 16'd3, 1'b1}},
        // bad leads: stray continuation, 0xFF
        '{8'h80, 1'b0, 1'b1, '{utf8p_pkg::REPLACEMENT_CP, 1'b0, 3'd1, 16'd2, 16'd4, 1'b1}},
        '{8'hFF, 1'b0, 1'b1, '{utf8p_pkg::REPLACEMENT_CP, 1'b0, 3'd1, 16'd2, 16'd5, 1'b1}},
        // broken three-byte sequence, ASCII breaks it
        '{8'hE2, 1'b0, 1'b0, NO_CHECK},
        '{8'h82, 1'b0, 1'b0, NO_CHECK},
        '{8'h41, 1'b0, 1'b0, NO_CHECK},
        // lead broken by another lead, then end of source mid-sequence
        '{8'hC3, 1'b0, 1'b0, NO_CHECK},
        '{8'hF0, 1'b0, 1'b0, NO_CHECK},
        '{8'h9F, 1'b1, 1'b0, NO_CHECK},
        // lone lead with end of source, after position reset
        '{8'hC3, 1'b1, 1'b1, '{utf8p_pkg::REPLACEMENT_CP, 1'b0, 3'd1, 16'd1, 16'd1, 1'b1}},
        // broken four-byte sequence whose breaker is itself a lead flushed by
        // end of source: four words from one byte
        '{8'hF0, 1'b0, 1'b0, NO_CHECK},
        '{8'h9F, 1'b0, 1'b0, NO_CHECK},
        '{8'h98, 1'b0, 1'b0, NO_CHECK},
        '{8'hC0, 1'b1, 1'b0, NO_CHECK}
    };

    byte_item_t src_bytes [$];      // bytes still to be offered
    char_word_t pending_chars [$];  // predicted char words, oldest first
    char_word_t run_q [$];          // words produced by the byte just decoded

    // Predictor state
    logic [1:0]                        seq_need;   // continuation bytes the open sequence needs
    logic [1:0]                        seq_held;   // continuation bytes seen so far
    logic [utf8p_pkg::CP_BITS-1:0]     seq_bits;   // code point bits gathered so far
    logic [utf8p_pkg::LINE_BITS-1:0]   cur_line;
    logic [utf8p_pkg::COLUMN_BITS-1:0] cur_col;

    int  err_cnt;
    int  burst_left;
    int  gap_left;
    bit  random_phase;  // random stimulus running; arms the long receiver hold

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Emit one char word at the current position, then advance the position.
    // Only a well formed newline bumps the line; everything else, U+FFFD
    // included, bumps the column. Both counters stick at all ones.
    task automatic put_char(input logic [utf8p_pkg::CP_BITS-1:0] cp, input logic ok,
                            input logic [2:0] nb);
        char_word_t w;
        w.cp   = cp;
        w.ok   = ok;
        w.nb   = nb;
        w.line = utf8p_pkg::POS_OUT_BITS'(cur_line);
        w.col  = utf8p_pkg::POS_OUT_BITS'(cur_col);
        w.last = 1'b0;
        run_q.push_back(w);
        if (ok && cp == utf8p_pkg::NEWLINE_CP)
        begin
            if (cur_line != '1)
                cur_line++;
            cur_col = 1;
        end
        else if (cur_col != '1)
        begin
            cur_col++;
        end
    endtask

    // Open sequence dies: one U+FFFD for the lead, one per held continuation.
    task automatic flush_seq();
        if (seq_need != 0)
        begin
            put_char(utf8p_pkg::REPLACEMENT_CP, 1'b0, 3'd1);
            repeat (seq_held) put_char(utf8p_pkg::REPLACEMENT_CP, 1'b0, 3'd1);
            seq_need = '0;
            seq_held = '0;
            seq_bits = '0;
        end
    endtask

    task automatic reset_decoder();
        seq_need = '0;
        seq_held = '0;
        seq_bits = '0;
        cur_line = 1;
        cur_col  = 1;
    endtask

    // Decode one accepted byte into run_q, last word flagged.
    task automatic decode_byte(input logic [7:0] b, input logic eos);
        logic [utf8p_pkg::CP_BITS-1:0] cp;
        logic [2:0]                    nb;
        run_q.delete();
        if (seq_need != 0 && b[7:6] == 2'b10)
        begin
            seq_bits = {seq_bits[utf8p_pkg::CP_BITS-7:0], b[5:0]};
            seq_held++;
            if (seq_held >= seq_need)
            begin
                nb = 3'(seq_need) + 3'd1;
                cp = seq_bits;
                seq_need = '0;
                seq_held = '0;
                seq_bits = '0;
                put_char(cp, 1'b1, nb);
            end
        end
        else
        begin
            flush_seq();
            if (!b[7])
                put_char(utf8p_pkg::CP_BITS'(b), 1'b1, 3'd1);
            else if (b[7:5] == 3'b110)
            begin
                seq_need = 2'd1;
                seq_held = '0;
                seq_bits = utf8p_pkg::CP_BITS'(b[4:0]);
            end
            else if (b[7:4] == 4'b1110)
            begin
                seq_need = 2'd2;
                seq_held = '0;
                seq_bits = utf8p_pkg::CP_BITS'(b[3:0]);
            end
            else if (b[7:3] == 5'b11110)
            begin
                seq_need = 2'd3;
                seq_held = '0;
                seq_bits = utf8p_pkg::CP_BITS'(b[2:0]);
            end
            else
                put_char(utf8p_pkg::REPLACEMENT_CP, 1'b0, 3'd1);
        end
        if (eos)
        begin
            flush_seq();
            reset_decoder();
        end
        if (run_q.size() != 0)
            run_q[run_q.size()-1].last = 1'b1;
    endtask

    function automatic byte_item_t plain(input logic [7:0] b, input logic eos);
        plain = '{b, eos, 1'b0, NO_CHECK};
    endfunction

    // ------------------------------------------------------------------
    // Byte sender: bursts of random length, random gaps between bursts.
    // A word is predicted the moment it is accepted. Gaps are only opened
    // after an accept, so an offered word is never withdrawn.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_bytes
        byte_item_t cur;
        logic       offer;
        if (!rst_n)
        begin
            bytes.valid         <= 1'b0;
            bytes.data_byte     <= 8'h00;
            bytes.end_of_source <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end
        else
        begin
            if (bytes.valid && bytes.ready)
            begin
                cur = src_bytes.pop_front();
                decode_byte(cur.b, cur.eos);
                // typed rows: the hand-written word replaces the predicted one
                if (cur.typed && run_q.size() != 0)
                    run_q[run_q.size()-1] = cur.want;
                foreach (run_q[k])
                    pending_chars.push_back(run_q[k]);
                burst_left--;
                if (burst_left <= 0)
                begin
                    // now and then a long burst, so there are stretches with no idling
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 96)
                                                             : $urandom_range(1, 12);
                    gap_left   = $urandom_range(1, 9);
                end
            end
            offer = 1'b0;
            if (gap_left != 0)
                gap_left--;
            else if (src_bytes.size() != 0)
                offer = 1'b1;
            bytes.valid <= offer;
            if (offer)
            begin
                bytes.data_byte     <= src_bytes[0].b;
                bytes.end_of_source <= src_bytes[0].eos;
            end
        end
    end

    // ------------------------------------------------------------------
    // Char receiver: ready follows a rotating stall pattern, reloaded whenever
    // pat_age wraps (sometimes all ones). Once in the random phase it holds off
    // once, long enough that the run register fills and bytes.ready drops.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_ready
        logic [15:0] stall_pat;
        int          pat_age;
        int          hold_left;
        int          rand_cycles;
        bit          hold_done;
        if (!rst_n)
        begin
            chars.ready <= 1'b0;
            stall_pat   = 16'hFFFF;
            pat_age     = 0;
            hold_left   = 0;
            rand_cycles = 0;
            hold_done   = 1'b0;
        end
        else
        begin
            if (random_phase && !hold_done)
            begin
                rand_cycles++;
                if (rand_cycles == 40)
                begin
                    hold_left = 300;
                    hold_done = 1'b1;
                end
            end
            if (hold_left != 0)
            begin
                hold_left--;
                chars.ready <= 1'b0;
            end
            else
            begin
                chars.ready <= stall_pat[0];
                stall_pat = {stall_pat[0], stall_pat[15:1]};
                pat_age++;
                if (pat_age == 48)
                begin
                    pat_age   = 0;
                    stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                            : 16'($urandom | $urandom);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic cmp_field(input string what, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %h actual %h", $time, what, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge clk)
    begin : watch_chars
        char_word_t want;
        if (rst_n && chars.valid && chars.ready)
        begin
            if (pending_chars.size() == 0)
            begin
                $display("%0t ns: unexpected char word, expected none actual cp %h",
                         $time, chars.codepoint);
                err_cnt++;
            end
            else
            begin
                want = pending_chars.pop_front();
                cmp_field("codepoint",     32'(want.cp),   32'(chars.codepoint));
                cmp_field("char_valid",    32'(want.ok),   32'(chars.char_valid));
                cmp_field("byte_count",    32'(want.nb),   32'(chars.byte_count));
                cmp_field("line_number",   32'(want.line), 32'(chars.line_number));
                cmp_field("column_number", 32'(want.col),  32'(chars.column_number));
                cmp_field("last_of_run",   32'(want.last), 32'(chars.last_of_run));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer. Queues are loaded on the falling edge so the sender never
    // sees a half-loaded queue at a rising edge.
    // ------------------------------------------------------------------
    initial
    begin : run_all
        int          n_rand;
        int          pick;
        int          cls;
        int          keep;
        logic [31:0] bits;
        logic [7:0]  lead;

        rst_n               = 1'b0;
        bytes.valid         = 1'b0;
        bytes.data_byte     = 8'h00;
        bytes.end_of_source = 1'b0;
        chars.ready         = 1'b0;
        random_phase        = 1'b0;
        err_cnt             = 0;
        reset_decoder();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        @(negedge clk);
        foreach (dir_tab[i])
            src_bytes.push_back(dir_tab[i]);
        while (src_bytes.size() != 0 || pending_chars.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);

        // Random text: mostly well formed characters with random payload,
        // some cut-short sequences and raw noise bytes, the odd end of source.
        random_phase = 1'b1;
        n_rand = 0;
        while (n_rand < 245)
        begin
            pick = $urandom_range(0, 99);
            bits = $urandom;
            if (pick < 65)
            begin
                cls = $urandom_range(1, 4);
                keep = cls - 1;
            end
            else if (pick < 80)
            begin
                cls = $urandom_range(2, 4);
                keep = $urandom_range(0, cls - 2);
            end
            else
            begin
                cls = 0;
                keep = 0;
            end
            case (cls)
                1:       lead = ($urandom_range(0, 7) == 0) ? 8'h0A : {1'b0, bits[6:0]};
                2:       lead = {3'b110, bits[4:0]};
                3:       lead = {4'b1110, bits[3:0]};
                4:       lead = {5'b11110, bits[2:0]};
                default: lead = 8'($urandom_range(0, 255));
            endcase
            src_bytes.push_back(plain(lead, $urandom_range(0, 39) == 0));
            n_rand++;
            for (int k = 0; k < keep; k++)
            begin
                src_bytes.push_back(plain({2'b10, bits[8 + 6*k +: 6]},
                                          $urandom_range(0, 39) == 0));
                n_rand++;
            end
        end
        while (src_bytes.size() != 0 || pending_chars.size() != 0) @(negedge clk);
        // a lone lead can still be in flight with nothing expected
        repeat (10) @(negedge clk);

        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/utf8p_pkg.sv
rtl/utf8p_if.sv
rtl/utf8p_decode.sv
rtl/utf8p_emit.sv
rtl/utf8_decoder_with_position_unit.sv
rtl/utf8p_checker.sv
tb/tb_utf8_decoder_with_position_unit.sv
